// File: src/assert_macros.svh
// Assertion macros for the encoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent holds, consequent holds in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: implication failed");

// Antecedent holds, consequent holds in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle implication failed");

// Condition must never hold.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("%m: forbidden condition seen");

`endif

// File: src/b32enc_pkg.sv
// Constants and polymod/alphabet functions for the address encoder.
`default_nettype none

package b32enc_pkg;

	localparam int PREFIX_MAX_CHARS = 8;

	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 64;

	localparam logic [CFG_INDEX_W-1:0] CFG_PREFIX_CHARS  = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_PREFIX_LENGTH = 1'd1;

	localparam logic [29:0] GEN_POLY [5] = '{
		30'h3b6a57b2, 30'h26508e6d, 30'h1ea119fa, 30'h3d4233dd, 30'h2a1462b3
	};
	localparam logic [29:0] CONST_BECH32  = 30'h00000001;
	localparam logic [29:0] CONST_BECH32M = 30'h2bc830a3;
	localparam logic [6:0]  CHAR_SEPARATOR = 7'h31;

	localparam logic [7:0] ALPHABET [32] = '{
		"q", "p", "z", "r", "y", "9", "x", "8",
		"g", "f", "2", "t", "v", "d", "w", "0",
		"s", "3", "j", "n", "5", "4", "k", "h",
		"c", "e", "6", "m", "u", "a", "7", "l"
	};

	// One step of the BCH checksum over a 5-bit symbol.
	function automatic logic [29:0] polymod_step(logic [29:0] c, logic [4:0] sym);
		logic [4:0]  top;
		logic [29:0] r;
		top = c[29:25];
		r   = {c[24:0], 5'b0} ^ {25'b0, sym};
		for (int j = 0; j < 5; j++) begin
			if (top[j]) begin
				r = r ^ GEN_POLY[j];
			end
		end
		return r;
	endfunction

	function automatic logic [6:0] alpha_char(logic [4:0] sym);
		return ALPHABET[sym][6:0];
	endfunction

endpackage

`default_nettype wire

// File: src/b32enc_if.sv
// Stream interfaces: program byte channel and address character channel.
`default_nettype none

interface b32enc_prog_if;
	logic       valid;
	logic       ready;
	logic [7:0] program_byte;
	logic [4:0] witness_version;
	logic       first_byte;
	logic       last_byte;

	modport source (output valid, program_byte, witness_version, first_byte, last_byte,
		input ready);
	modport sink (input valid, program_byte, witness_version, first_byte, last_byte,
		output ready);
endinterface

interface b32enc_addr_if;
	logic       valid;
	logic       ready;
	logic [6:0] address_char;
	logic       final_char;

	modport source (output valid, address_char, final_char, input ready);
	modport sink (input valid, address_char, final_char, output ready);
endinterface

`default_nettype wire

// File: src/bech32m_address_encoder_unit.sv
// Streaming bech32/bech32m segwit address encoder, top level.
//
// prog_ch takes one witness program byte per transaction, with the version and
// first/last marks. addr_ch returns the address one ASCII character per
// transaction; final_char marks the last checksum character. The prefix sits in
// two registers written through cfg_we/cfg_index/cfg_data; the user must write
// them only while the block idles, which the block itself does not enforce.
//
// One checksum step unit is shared by every symbol, so the sequencer handles
// them one at a time, and prog_ch is not ready until the byte is done. A plain
// byte yields 1 or 2 data symbols. A first byte adds L high-part updates
// (L = prefix length, capped at 8), the zero separator, L prefix characters,
// '1' and the version. A last byte adds an optional pad symbol, 6 zero updates
// and 6 checksum characters. Results sit in one output register; while addr_ch
// stalls with it full, the sequencer holds on any character cycle. Reset clears
// the checksum to one, the leftover bits and version to zero, and the prefix
// registers to "bc" of length two. No clearing pass is needed.
`default_nettype none

module bech32m_address_encoder_unit
	import b32enc_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	b32enc_prog_if.sink                 prog_ch,
	b32enc_addr_if.source               addr_ch
);

	`include "assert_macros.svh"

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_PHI  = 4'd1;
	localparam logic [3:0] ST_PSEP = 4'd2;
	localparam logic [3:0] ST_PLO  = 4'd3;
	localparam logic [3:0] ST_SEP1 = 4'd4;
	localparam logic [3:0] ST_VER  = 4'd5;
	localparam logic [3:0] ST_DATA = 4'd6;
	localparam logic [3:0] ST_PAD  = 4'd7;
	localparam logic [3:0] ST_ZERO = 4'd8;
	localparam logic [3:0] ST_CHK  = 4'd9;

	logic [63:0] pfx_chars_q;
	logic [3:0]  pfx_len_q;
	logic [3:0]  state_q;
	logic [2:0]  idx_q;
	logic [29:0] chk_q;
	logic [11:0] acc_q;
	logic [3:0]  bits_q;
	logic        last_q;
	logic [3:0]  lo_bits_q;
	logic [2:0]  lo_cnt_q;
	logic [4:0]  ver_q;
	logic        out_valid_q;
	logic [6:0]  out_char_q;
	logic        out_final_q;

	logic [3:0]  len_sat;
	logic [2:0]  len_m1;
	logic [7:0]  pfx_byte;
	logic        can_push;
	logic        accept;
	logic        feed_en;
	logic [4:0]  feed_sym;
	logic [29:0] chk_step;
	logic        emit;
	logic        push;
	logic [6:0]  emit_char;
	logic        emit_final;
	logic [4:0]  alpha_sym;
	logic [3:0]  nb;
	logic [4:0]  data_sym;
	logic [11:0] acc_rem;
	logic [8:0]  pad_wide;
	logic [29:0] chk_x;
	logic [4:0]  chk_sym;

	assign len_sat  = (pfx_len_q > 4'(PREFIX_MAX_CHARS)) ? 4'(PREFIX_MAX_CHARS) : pfx_len_q;
	assign len_m1   = 3'(len_sat - 4'd1);
	assign pfx_byte = pfx_chars_q[idx_q*8 +: 8];
	assign can_push = !out_valid_q || addr_ch.ready;
	assign accept   = prog_ch.valid && prog_ch.ready;
	assign prog_ch.ready = (state_q == ST_IDLE);

	// Symbol extraction from the bit accumulator.
	assign nb       = bits_q - 4'd5;
	assign data_sym = 5'(acc_q >> nb);
	assign acc_rem  = acc_q & 12'((13'd1 << nb) - 13'd1);
	assign pad_wide = {5'b0, acc_q[3:0]} << (4'd5 - bits_q);

	assign chk_x = chk_q ^ ((ver_q == 5'd0) ? CONST_BECH32 : CONST_BECH32M);

	always_comb begin
		case (idx_q)
			3'd0:    chk_sym = chk_x[29:25];
			3'd1:    chk_sym = chk_x[24:20];
			3'd2:    chk_sym = chk_x[19:15];
			3'd3:    chk_sym = chk_x[14:10];
			3'd4:    chk_sym = chk_x[9:5];
			default: chk_sym = chk_x[4:0];
		endcase
	end

	always_comb begin
		feed_en    = 1'b0;
		feed_sym   = 5'd0;
		emit       = 1'b0;
		alpha_sym  = 5'd0;
		emit_char  = 7'd0;
		emit_final = 1'b0;
		case (state_q)
			ST_PHI: begin
				feed_en  = 1'b1;
				feed_sym = {2'b0, pfx_byte[7:5]};
			end
			ST_PSEP: begin
				feed_en = 1'b1;
			end
			ST_PLO: begin
				feed_en   = 1'b1;
				feed_sym  = pfx_byte[4:0];
				emit      = 1'b1;
				emit_char = pfx_byte[6:0];
			end
			ST_SEP1: begin
				emit      = 1'b1;
				emit_char = CHAR_SEPARATOR;
			end
			ST_VER: begin
				feed_en   = 1'b1;
				feed_sym  = ver_q;
				emit      = 1'b1;
				alpha_sym = ver_q;
				emit_char = alpha_char(alpha_sym);
			end
			ST_DATA: begin
				feed_en   = 1'b1;
				feed_sym  = data_sym;
				emit      = 1'b1;
				alpha_sym = data_sym;
				emit_char = alpha_char(alpha_sym);
			end
			ST_PAD: begin
				feed_en   = 1'b1;
				feed_sym  = pad_wide[4:0];
				emit      = 1'b1;
				alpha_sym = pad_wide[4:0];
				emit_char = alpha_char(alpha_sym);
			end
			ST_ZERO: begin
				feed_en = 1'b1;
			end
			ST_CHK: begin
				emit       = 1'b1;
				alpha_sym  = chk_sym;
				emit_char  = alpha_char(alpha_sym);
				emit_final = (idx_q == 3'd5);
			end
			default: begin
			end
		endcase
	end

	assign chk_step = polymod_step(chk_q, feed_sym);
	assign push     = emit && can_push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pfx_chars_q <= 64'd25442;
			pfx_len_q   <= 4'd2;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PREFIX_CHARS:  pfx_chars_q <= cfg_data;
				CFG_PREFIX_LENGTH: pfx_len_q   <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			idx_q     <= 3'd0;
			chk_q     <= 30'd1;
			acc_q     <= 12'd0;
			bits_q    <= 4'd0;
			last_q    <= 1'b0;
			lo_bits_q <= 4'd0;
			lo_cnt_q  <= 3'd0;
			ver_q     <= 5'd0;
		end else begin
			// Character cycles hold while the output register is blocked.
			if (feed_en && (!emit || can_push)) begin
				chk_q <= chk_step;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						last_q <= prog_ch.last_byte;
						idx_q  <= 3'd0;
						if (prog_ch.first_byte) begin
							chk_q   <= 30'd1;
							ver_q   <= prog_ch.witness_version;
							acc_q   <= {4'd0, prog_ch.program_byte};
							bits_q  <= 4'd8;
							state_q <= (len_sat == 4'd0) ? ST_PSEP : ST_PHI;
						end else begin
							acc_q   <= {lo_bits_q, prog_ch.program_byte};
							bits_q  <= {1'b0, lo_cnt_q} + 4'd8;
							state_q <= ST_DATA;
						end
					end
				end
				ST_PHI: begin
					if (idx_q == len_m1) begin
						idx_q   <= 3'd0;
						state_q <= ST_PSEP;
					end else begin
						idx_q <= idx_q + 3'd1;
					end
				end
				ST_PSEP: begin
					state_q <= (len_sat == 4'd0) ? ST_SEP1 : ST_PLO;
				end
				ST_PLO: begin
					if (can_push) begin
						if (idx_q == len_m1) begin
							idx_q   <= 3'd0;
							state_q <= ST_SEP1;
						end else begin
							idx_q <= idx_q + 3'd1;
						end
					end
				end
				ST_SEP1: begin
					if (can_push) begin
						state_q <= ST_VER;
					end
				end
				ST_VER: begin
					if (can_push) begin
						state_q <= ST_DATA;
					end
				end
				ST_DATA: begin
					if (can_push) begin
						acc_q  <= acc_rem;
						bits_q <= nb;
						if (nb < 4'd5) begin
							if (last_q) begin
								idx_q   <= 3'd0;
								state_q <= (nb != 4'd0) ? ST_PAD : ST_ZERO;
							end else begin
								lo_bits_q <= acc_rem[3:0];
								lo_cnt_q  <= nb[2:0];
								state_q   <= ST_IDLE;
							end
						end
					end
				end
				ST_PAD: begin
					if (can_push) begin
						idx_q   <= 3'd0;
						state_q <= ST_ZERO;
					end
				end
				ST_ZERO: begin
					if (idx_q == 3'd5) begin
						idx_q   <= 3'd0;
						state_q <= ST_CHK;
					end else begin
						idx_q <= idx_q + 3'd1;
					end
				end
				ST_CHK: begin
					if (can_push) begin
						if (idx_q == 3'd5) begin
							idx_q     <= 3'd0;
							chk_q     <= 30'd1;
							lo_bits_q <= 4'd0;
							lo_cnt_q  <= 3'd0;
							state_q   <= ST_IDLE;
						end else begin
							idx_q <= idx_q + 3'd1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register: refill on a push, drop once the transaction is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (addr_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_char_q  <= emit_char;
			out_final_q <= emit_final;
		end
	end

	assign addr_ch.valid        = out_valid_q;
	assign addr_ch.address_char = out_char_q;
	assign addr_ch.final_char   = out_final_q;

	`ASSERT_NEVER(a_data_short, clk, arst_n, state_q == ST_DATA && bits_q < 4'd5)
	`ASSERT_NEVER(a_leftover_range, clk, arst_n, lo_cnt_q > 3'd4)
	`ASSERT_IMPLIES(a_pad_bits, clk, arst_n, state_q == ST_PAD, bits_q != 4'd0 && bits_q < 4'd5)
	`ASSERT_NEXT(a_final_restart, clk, arst_n, state_q == ST_CHK && push && idx_q == 3'd5, state_q == ST_IDLE && chk_q == 30'd1)

endmodule

`default_nettype wire
